/* src/pmt_pkg.sv */
package pmt_pkg;

  // Width of the tracked cursor coordinates.
  localparam int POSITION_BITS = 12;

  // Fixed field widths of the channels and the configuration port.
  localparam int LIMIT_BITS   = 12;
  localparam int OUT_POS_BITS = 12;
  localparam int BUTTON_BITS  = 3;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 12;

  // Screen size used after reset and whenever a limit register holds zero.
  localparam logic [LIMIT_BITS-1:0] DEFAULT_WIDTH  = LIMIT_BITS'(1024);
  localparam logic [LIMIT_BITS-1:0] DEFAULT_HEIGHT = LIMIT_BITS'(768);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

endpackage

/* src/pmt_if.sv */
interface pmt_byte_if;
  logic       valid;
  logic       ready;
  logic       from_aux;
  logic [7:0] data_byte;

  modport source (output valid, output from_aux, output data_byte, input ready);
  modport sink   (input valid, input from_aux, input data_byte, output ready);
endinterface

interface pmt_pos_if;
  logic                             valid;
  logic                             ready;
  logic [pmt_pkg::OUT_POS_BITS-1:0] pos_x;
  logic [pmt_pkg::OUT_POS_BITS-1:0] pos_y;
  logic [pmt_pkg::BUTTON_BITS-1:0]  buttons;

  modport source (output valid, output pos_x, output pos_y, output buttons, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input buttons, output ready);
endinterface

/* src/ps2_mouse_packet_tracker.sv */
// PS/2 mouse packet tracker. Bytes from the keyboard controller enter on
// byte_stream, each tagged with from_aux; only mouse-channel bytes count.
// The block collects the standard three-byte packet (flag byte, X delta,
// Y delta), resynchronizing on a first byte whose bit 3 is set, drops packets
// with an overflow flag, and otherwise moves the cursor (X added, Y
// subtracted so that rows grow downward), clamps it to the screen size and
// sends one transfer on pointer with the new position and the buttons. The
// cursor starts at 512, 384. Screen width and height are written through the
// cfg port (index 0 and 1); zero selects 1024 by 768, and a new size takes
// effect with the next packet. One byte is accepted every clock cycle; a
// byte passes an input register and then the result register, which raises
// pointer.valid for the third byte of its packet. The only thing that stops
// the input is a result held back by pointer.ready.
module ps2_mouse_packet_tracker (
  input  logic                                clk,
  input  logic                                rst,
  pmt_byte_if.sink                            byte_stream,
  pmt_pos_if.source                           pointer,
  input  logic                                cfg_we,
  input  logic [pmt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pmt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PB = pmt_pkg::POSITION_BITS;
  localparam int LB = pmt_pkg::LIMIT_BITS;
  // Signed working width for cursor plus a nine-bit delta.
  localparam int CALC_BITS = ((PB > LB) ? PB : LB) + 2;
  localparam logic [CALC_BITS-1:0] POS_MAX = CALC_BITS'((1 << PB) - 1);

  // Packet assembly phase, one-hot.
  typedef enum logic [2:0] {
    AWAIT_FLAG = 3'b001,
    AWAIT_X    = 3'b010,
    AWAIT_Y    = 3'b100
  } phase_t;

  // Configuration registers.
  logic [LB-1:0] screen_width;
  logic [LB-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pmt_pkg::DEFAULT_WIDTH;
      screen_height <= pmt_pkg::DEFAULT_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmt_pkg::REG_SCREEN_WIDTH:  screen_width  <= LB'(cfg_data);
        pmt_pkg::REG_SCREEN_HEIGHT: screen_height <= LB'(cfg_data);
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       in_valid;
  logic       in_aux;
  logic [7:0] in_data;

  // Tracker state.
  phase_t        phase;
  phase_t        phase_next;
  logic [7:0]    flag_byte;
  logic [7:0]    x_delta_byte;
  logic [PB-1:0] cursor_x;
  logic [PB-1:0] cursor_y;
  logic [2:0]    button_bits;

  // Result register stage.
  logic                             out_valid;
  logic [pmt_pkg::OUT_POS_BITS-1:0] out_x;
  logic [pmt_pkg::OUT_POS_BITS-1:0] out_y;

  logic advance;
  logic take_flag;
  logic take_x;
  logic emit;

  // The registered byte moves on unless it makes a result while the
  // previous result still waits for its transfer.
  assign advance = in_valid && (!emit || !out_valid || pointer.ready);
  assign byte_stream.ready = !in_valid || advance;

  always_comb begin
    phase_next = phase;
    take_flag  = 1'b0;
    take_x     = 1'b0;
    emit       = 1'b0;
    if (in_aux) begin
      unique case (phase)
        AWAIT_X: begin
          take_x     = 1'b1;
          phase_next = AWAIT_Y;
        end
        AWAIT_Y: begin
          phase_next = AWAIT_FLAG;
          emit       = (flag_byte[7:6] == 2'b00);
        end
        default: begin
          // Awaiting the flag byte; an unsynchronized byte has bit 3 clear.
          if (in_data[3]) begin
            take_flag  = 1'b1;
            phase_next = AWAIT_X;
          end
        end
      endcase
    end
  end

  // Nine-bit deltas, sign bits from the flag byte.
  logic signed [8:0]           dx;
  logic signed [8:0]           dy;
  logic signed [CALC_BITS-1:0] nx;
  logic signed [CALC_BITS-1:0] ny;
  logic [LB-1:0]               width_eff;
  logic [LB-1:0]               height_eff;
  logic [PB-1:0]               new_x;
  logic [PB-1:0]               new_y;

  assign dx = {flag_byte[4], x_delta_byte};
  assign dy = {flag_byte[5], in_data};
  assign nx = $signed({{(CALC_BITS-PB){1'b0}}, cursor_x}) + {{(CALC_BITS-9){dx[8]}}, dx};
  assign ny = $signed({{(CALC_BITS-PB){1'b0}}, cursor_y}) - {{(CALC_BITS-9){dy[8]}}, dy};

  assign width_eff  = (screen_width  == '0) ? pmt_pkg::DEFAULT_WIDTH  : screen_width;
  assign height_eff = (screen_height == '0) ? pmt_pkg::DEFAULT_HEIGHT : screen_height;

  // Clamp to 0 .. limit-1 and to the largest representable position.
  function automatic logic [PB-1:0] clamp_pos(input logic signed [CALC_BITS-1:0] v,
                                              input logic [LB-1:0] limit);
    logic [CALC_BITS-1:0] top;
    top = CALC_BITS'(limit) - CALC_BITS'(1);
    if (top > POS_MAX) begin
      top = POS_MAX;
    end
    if (v[CALC_BITS-1]) begin
      clamp_pos = '0;
    end else if ($unsigned(v) > top) begin
      clamp_pos = PB'(top);
    end else begin
      clamp_pos = PB'($unsigned(v));
    end
  endfunction

  assign new_x = clamp_pos(nx, width_eff);
  assign new_y = clamp_pos(ny, height_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      phase       <= AWAIT_FLAG;
      cursor_x    <= PB'(pmt_pkg::DEFAULT_WIDTH / 2);
      cursor_y    <= PB'(pmt_pkg::DEFAULT_HEIGHT / 2);
      button_bits <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (byte_stream.ready) begin
        in_valid <= byte_stream.valid;
      end
      if (advance) begin
        phase <= phase_next;
        if (emit) begin
          cursor_x    <= new_x;
          cursor_y    <= new_y;
          button_bits <= flag_byte[2:0];
        end
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (pointer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (byte_stream.ready && byte_stream.valid) begin
      in_aux  <= byte_stream.from_aux;
      in_data <= byte_stream.data_byte;
    end
    if (advance && take_flag) begin
      flag_byte <= in_data;
    end
    if (advance && take_x) begin
      x_delta_byte <= in_data;
    end
    if (advance && emit) begin
      out_x <= pmt_pkg::OUT_POS_BITS'(new_x);
      out_y <= pmt_pkg::OUT_POS_BITS'(new_y);
    end
  end

  // The latched buttons change only together with a new result, so they
  // drive the buttons field of the pointer channel directly.
  assign pointer.valid   = out_valid;
  assign pointer.pos_x   = out_x;
  assign pointer.pos_y   = out_y;
  assign pointer.buttons = pmt_pkg::BUTTON_BITS'(button_bits);

endmodule
